### rtl/core/multi_stack_shared_store_core_defines.svh
// ----------------------------------------------------------------------------
// multi_stack_shared_store_core assertion macros
// Shared concurrent assertion forms, clocked on clk, off while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef MULTI_STACK_SHARED_STORE_CORE_DEFINES_SVH
`define MULTI_STACK_SHARED_STORE_CORE_DEFINES_SVH

// Same-cycle implication: cons is checked from the edge where ante holds.
`define MSS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> cons) \
		else $error(msg);

// Next-cycle implication: cons is checked in the cycle after ante holds.
`define MSS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> cons) \
		else $error(msg);

`endif

### rtl/core/mss_pkg.sv
// ----------------------------------------------------------------------------
// mss_pkg
// Sizes, opcodes and beat types for the shared-store multi-stack core.
// ----------------------------------------------------------------------------
package mss_pkg;

	localparam int unsigned NUM_STACKS = 4;
	localparam int unsigned NUM_SLOTS  = 16;
	localparam int unsigned DATA_W     = 32;
	localparam int unsigned STACK_W    = 2;
	// slot address, and link/head width that also holds the null code
	localparam int unsigned SLOT_W     = $clog2(NUM_SLOTS);
	localparam int unsigned LINK_W     = $clog2(NUM_SLOTS + 1);
	localparam logic [LINK_W-1:0] NIL  = LINK_W'(NUM_SLOTS);

	localparam logic MODE_PUSH = 1'b0;
	localparam logic MODE_POP  = 1'b1;

	typedef struct packed {
		logic                     mode;
		logic [STACK_W-1:0]       stack_number;
		logic signed [DATA_W-1:0] push_value;
	} in_item_t;

	typedef struct packed {
		logic                     ok;
		logic signed [DATA_W-1:0] pop_value;
	} out_item_t;

	// controller -> datapath
	typedef struct packed {
		logic load;   // capture item, launch memory reads
		logic exec;   // commit update, fill result register
	} dp_cmd_t;

endpackage

### rtl/core/multi_stack_shared_store_core.sv
// ----------------------------------------------------------------------------
// multi_stack_shared_store_core
// Four LIFO stacks over one 16-slot store, linked per slot, with a free list.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_data): one beat is one operation.
//     mode 0 pushes push_value onto stack stack_number, mode 1 pops it.
//   Output channel (out_valid/out_ready/out_data): exactly one result beat
//     per input beat, in order. ok=0 means the store was full (push) or the
//     stack was empty (pop); pop_value is the popped value, else zero.
//   Timing: an accepted beat is captured and its memory reads launched; in
//     the next cycle the update is committed and the result register is
//     filled, set by the registered read of the link and data memories. No
//     new beat is taken while an operation is waiting for its commit.
//   Stall: the result sits in an output register. A new beat is taken only
//     when that register is empty or is drained in the same cycle, so a
//     stalled receiver holds off the sender after at most one result.
//   Reset (arst_n low): all stacks empty, free list runs slot 0..15 in order.
//     No clearing pass; link entries carry valid bits instead.
// ----------------------------------------------------------------------------
module multi_stack_shared_store_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  mss_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output mss_pkg::out_item_t out_data
);

	// sequencing commands from the controller to the datapath
	mss_pkg::dp_cmd_t cmd;

	mss_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// heads, free list, memories and result register
	mss_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.in_data  (in_data),
		.out_data (out_data)
	);

endmodule

### rtl/core/mss_ram.sv
// ----------------------------------------------------------------------------
// mss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mss_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

### rtl/core/mss_ctrl.sv
// ----------------------------------------------------------------------------
// mss_ctrl
// Two-state sequencer: capture/read, then commit/respond. Owns out_valid.
// ----------------------------------------------------------------------------
module mss_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	output logic             out_valid,
	input  logic             out_ready,
	output mss_pkg::dp_cmd_t cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_EXEC = 1'b1;

	logic state_q;
	logic out_valid_q;

	// result register must be free (or draining) before a new beat enters
	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign cmd.load  = in_valid && in_ready;
	assign cmd.exec  = (state_q == ST_EXEC);
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

### rtl/core/mss_dp.sv
// ----------------------------------------------------------------------------
// mss_dp
// Stack heads, free-list head, slot data and link memories, result register.
// ----------------------------------------------------------------------------
module mss_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  mss_pkg::dp_cmd_t    cmd,
	input  mss_pkg::in_item_t   in_data,
	output mss_pkg::out_item_t  out_data
);

	logic [mss_pkg::LINK_W-1:0]  stack_head_q [mss_pkg::NUM_STACKS];
	logic [mss_pkg::LINK_W-1:0]  free_head_q;
	logic [mss_pkg::NUM_SLOTS-1:0] link_vld_q;   // link entry written since reset

	logic                        mode_q;
	logic [mss_pkg::STACK_W-1:0] sn_q;
	logic [mss_pkg::DATA_W-1:0]  val_q;
	logic [mss_pkg::LINK_W-1:0]  slot_q;
	logic                        lnk_vld_s1;
	logic [mss_pkg::LINK_W-1:0]  lnk_def_s1;
	mss_pkg::out_item_t          out_q;

	logic [mss_pkg::LINK_W-1:0]  rd_slot;
	logic [mss_pkg::LINK_W-1:0]  link_rd;
	logic [mss_pkg::LINK_W-1:0]  link_cur;
	logic [mss_pkg::DATA_W-1:0]  data_rd;
	logic                        stack_ok;
	logic                        op_ok;
	logic                        data_we;
	logic                        link_we;
	logic [mss_pkg::LINK_W-1:0]  link_wdata;

	// slot touched by the op: free head on push, stack top on pop
	assign rd_slot = (in_data.mode == mss_pkg::MODE_POP) ?
		stack_head_q[in_data.stack_number] : free_head_q;

	// unwritten link entries read as their reset chain value (slot + 1)
	assign link_cur   = lnk_vld_s1 ? link_rd : lnk_def_s1;
	assign stack_ok   = (32'(sn_q) < mss_pkg::NUM_STACKS);
	assign op_ok      = stack_ok && (slot_q < mss_pkg::NIL);
	assign data_we    = cmd.exec && op_ok && (mode_q == mss_pkg::MODE_PUSH);
	assign link_we    = cmd.exec && op_ok;
	assign link_wdata = (mode_q == mss_pkg::MODE_PUSH) ? stack_head_q[sn_q] : free_head_q;

	mss_ram #(
		.WIDTH (mss_pkg::DATA_W),
		.DEPTH (mss_pkg::NUM_SLOTS)
	) u_data_ram (
		.clk     (clk),
		.wr_en   (data_we),
		.wr_addr (slot_q[mss_pkg::SLOT_W-1:0]),
		.wr_data (val_q),
		.rd_en   (cmd.load),
		.rd_addr (rd_slot[mss_pkg::SLOT_W-1:0]),
		.rd_data (data_rd)
	);

	mss_ram #(
		.WIDTH (mss_pkg::LINK_W),
		.DEPTH (mss_pkg::NUM_SLOTS)
	) u_link_ram (
		.clk     (clk),
		.wr_en   (link_we),
		.wr_addr (slot_q[mss_pkg::SLOT_W-1:0]),
		.wr_data (link_wdata),
		.rd_en   (cmd.load),
		.rd_addr (rd_slot[mss_pkg::SLOT_W-1:0]),
		.rd_data (link_rd)
	);

	// item capture and read-side bookkeeping
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q     <= in_data.mode;
			sn_q       <= in_data.stack_number;
			val_q      <= in_data.push_value;
			slot_q     <= rd_slot;
			lnk_vld_s1 <= link_vld_q[rd_slot[mss_pkg::SLOT_W-1:0]];
			lnk_def_s1 <= rd_slot + mss_pkg::LINK_W'(1);
		end
		if (cmd.exec) begin
			out_q.ok <= op_ok;
			if (op_ok && (mode_q == mss_pkg::MODE_POP)) begin
				out_q.pop_value <= data_rd;
			end else begin
				out_q.pop_value <= '0;
			end
		end
	end

	// list heads and link valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mss_pkg::NUM_STACKS; i++) begin
				stack_head_q[i] <= mss_pkg::NIL;
			end
			free_head_q <= '0;
			link_vld_q  <= '0;
		end else if (link_we) begin
			link_vld_q[slot_q[mss_pkg::SLOT_W-1:0]] <= 1'b1;
			if (mode_q == mss_pkg::MODE_PUSH) begin
				free_head_q        <= link_cur;
				stack_head_q[sn_q] <= slot_q;
			end else begin
				stack_head_q[sn_q] <= link_cur;
				free_head_q        <= slot_q;
			end
		end
	end

	assign out_data = out_q;

endmodule

### rtl/core/mss_checker.sv
// ----------------------------------------------------------------------------
// mss_checker
// Port-level checks on the core's sequencing, bound to the top level.
// ----------------------------------------------------------------------------
`include "multi_stack_shared_store_core_defines.svh"

module mss_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic               out_valid,
	input  logic               out_ready,
	input  mss_pkg::out_item_t out_data
);

	logic rx_stall;
	logic in_take;

	assign rx_stall = out_valid && !out_ready;
	assign in_take  = in_valid && in_ready;

	`MSS_ASSERT_NEXT(a_out_hold, rx_stall, out_valid && $stable(out_data), "result moved in stall")
	`MSS_ASSERT_NEXT(a_one_at_a_time, in_take, !in_ready, "second beat taken in flight")
	`MSS_ASSERT_SAME(a_result_latency, in_take, ##2 out_valid, "no result two cycles after accept")
	`MSS_ASSERT_SAME(a_no_take_when_full, rx_stall, !in_ready, "beat taken while result stalled")

endmodule

bind multi_stack_shared_store_core mss_checker u_mss_checker (.*);

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for multi_stack_shared_store_core: push/pop beats go in
// through valid/ready, and every result beat is compared in order against a
// behavioral copy of the stacks, links and free list kept in the bench.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int PLAN_LEN  = 25;
	localparam int RAND_LEN  = 550;
	localparam int HOLD_LEN  = 60;

	// one directed row; typed rows carry their expected result by hand
	typedef struct packed {
		logic                        mode;
		logic [mss_pkg::STACK_W-1:0] sn;
		logic [mss_pkg::DATA_W-1:0]  val;
		logic                        typed;
		logic                        ok;
		logic [mss_pkg::DATA_W-1:0]  pv;
	} plan_row_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	mss_pkg::in_item_t  in_data;
	logic               out_valid;
	logic               out_ready;
	mss_pkg::out_item_t out_data;

	// bench copy of the store
	logic signed [mss_pkg::DATA_W-1:0] slot_val  [mss_pkg::NUM_SLOTS];
	logic [mss_pkg::LINK_W-1:0]        slot_next [mss_pkg::NUM_SLOTS];
	logic [mss_pkg::LINK_W-1:0]        stack_top [mss_pkg::NUM_STACKS];
	logic [mss_pkg::LINK_W-1:0]        free_top;

	mss_pkg::out_item_t pending_results[$];
	int                 errors;
	int                 beats_in;
	bit                 rx_holding;

	// Directed part: empty pops after reset, fill all 16 slots with the value
	// extremes spread over every stack, one push into a full store, then a few
	// pops and a push that reuse freed slots.
	plan_row_t plan [PLAN_LEN] = '{
		'{mss_pkg::MODE_POP,  2'd0, 32'h0000_0000, 1'b1, 1'b0, 32'h0},
		'{mss_pkg::MODE_POP,  2'd1, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0},
		'{mss_pkg::MODE_POP,  2'd2, 32'h0000_0000, 1'b1, 1'b0, 32'h0},
		'{mss_pkg::MODE_POP,  2'd3, 32'hFFFF_FFFF, 1'b1, 1'b0, 32'h0},
		'{mss_pkg::MODE_PUSH, 2'd0, 32'h7FFF_FFFF, 1'b1, 1'b1, 32'h0},
		'{mss_pkg::MODE_PUSH, 2'd3, 32'h8000_0000, 1'b1, 1'b1, 32'h0},
		'{mss_pkg::MODE_PUSH, 2'd1, 32'h0000_0000, 1'b1, 1'b1, 32'h0},
		'{mss_pkg::MODE_PUSH, 2'd2, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0},
		'{mss_pkg::MODE_PUSH, 2'd0, 32'h0000_0001, 1'b1, 1'b1, 32'h0},
		'{mss_pkg::MODE_PUSH, 2'd1, 32'hAAAA_AAAA, 1'b1, 1'b1, 32'h0},
		'{mss_pkg::MODE_PUSH, 2'd2, 32'h5555_5555, 1'b1, 1'b1, 32'h0},
		'{mss_pkg::MODE_PUSH, 2'd3, 32'hFFFF_0000, 1'b1, 1'b1, 32'h0},
		'{mss_pkg::MODE_PUSH, 2'd0, 32'h0000_FFFF, 1'b1, 1'b1, 32'h0},
		'{mss_pkg::MODE_PUSH, 2'd1, 32'h1234_5678, 1'b1, 1'b1, 32'h0},
		'{mss_pkg::MODE_PUSH, 2'd3, 32'hDEAD_BEEF, 1'b1, 1'b1, 32'h0},
		'{mss_pkg::MODE_PUSH, 2'd2, 32'h7FFF_FFFE, 1'b1, 1'b1, 32'h0},
		'{mss_pkg::MODE_PUSH, 2'd0, 32'h8000_0001, 1'b1, 1'b1, 32'h0},
		'{mss_pkg::MODE_PUSH, 2'd1, 32'h0F0F_0F0F, 1'b1, 1'b1, 32'h0},
		'{mss_pkg::MODE_PUSH, 2'd2, 32'hF0F0_F0F0, 1'b1, 1'b1, 32'h0},
		'{mss_pkg::MODE_PUSH, 2'd3, 32'h0000_0002, 1'b1, 1'b1, 32'h0},
		'{mss_pkg::MODE_PUSH, 2'd1, 32'h1357_9BDF, 1'b1, 1'b0, 32'h0},  // store full
		'{mss_pkg::MODE_POP,  2'd3, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
		'{mss_pkg::MODE_POP,  2'd0, 32'h0000_0000, 1'b0, 1'b0, 32'h0},
		'{mss_pkg::MODE_PUSH, 2'd2, 32'h2468_ACE0, 1'b0, 1'b0, 32'h0},
		'{mss_pkg::MODE_POP,  2'd2, 32'h0000_0000, 1'b0, 1'b0, 32'h0}
	};

	multi_stack_shared_store_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	// 8 ns period
	initial clk = 1'b0;
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// hard stop well beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("tb_top: FAIL");
		$finish;
	end

	task automatic log_mismatch(input string msg);
		errors++;
		$display("mismatch @%0t: %s", $time, msg);
	endtask

	// Apply one operation to the bench copy and return its result beat.
	// Heads or links at or above NUM_SLOTS read as the null link.
	function automatic mss_pkg::out_item_t stack_op_result(input mss_pkg::in_item_t it);
		mss_pkg::out_item_t         r;
		logic [mss_pkg::LINK_W-1:0] s;
		r = '0;
		if (it.stack_number >= mss_pkg::NUM_STACKS)
			return r;
		if (it.mode == mss_pkg::MODE_PUSH) begin
			s = free_top;
			if (s >= mss_pkg::NUM_SLOTS)
				return r;   // no free slot
			free_top                   = slot_next[s];
			slot_val[s]                = it.push_value;
			slot_next[s]               = stack_top[it.stack_number];
			stack_top[it.stack_number] = s;
			r.ok = 1'b1;
		end else begin
			s = stack_top[it.stack_number];
			if (s >= mss_pkg::NUM_SLOTS)
				return r;   // stack empty
			stack_top[it.stack_number] = slot_next[s];
			slot_next[s]               = free_top;
			free_top                   = s;
			r.ok        = 1'b1;
			r.pop_value = slot_val[s];
		end
		return r;
	endfunction

	// Hold the beat until taken. Ready is looked at on the falling edge, where
	// everything has settled, and the beat goes in at the next rising edge.
	// Returns at that rising edge with valid still high.
	task automatic offer_beat(input mss_pkg::in_item_t it, input bit typed,
		input mss_pkg::out_item_t fixed);
		bit                 taken;
		mss_pkg::out_item_t r;
		taken = 1'b0;
		in_data  <= it;
		in_valid <= 1'b1;
		while (!taken) begin
			@(negedge clk);
			taken = in_ready;
			@(posedge clk);
		end
		r = stack_op_result(it);
		pending_results.push_back(typed ? fixed : r);
		beats_in++;
	endtask

	// Sender: directed rows, then random beats, in bursts with gaps between.
	initial begin : tx_main
		mss_pkg::in_item_t  it;
		mss_pkg::out_item_t fixed;
		bit                 typed;
		int                 burst_left;
		int                 gap;
		int                 push_pct;
		int                 n;
		errors     = 0;
		beats_in   = 0;
		rx_holding = 1'b0;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		in_data    = '0;
		for (int i = 0; i < mss_pkg::NUM_SLOTS; i++) begin
			slot_val[i]  = '0;
			slot_next[i] = (i + 1 < mss_pkg::NUM_SLOTS) ?
				mss_pkg::LINK_W'(i + 1) : mss_pkg::NIL;
		end
		for (int i = 0; i < mss_pkg::NUM_STACKS; i++)
			stack_top[i] = mss_pkg::NIL;
		free_top = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		burst_left = 0;
		for (n = 0; n < PLAN_LEN + RAND_LEN; n++) begin
			if (n < PLAN_LEN) begin
				it.mode         = plan[n].mode;
				it.stack_number = plan[n].sn;
				it.push_value   = plan[n].val;
				typed           = plan[n].typed;
				fixed.ok        = plan[n].ok;
				fixed.pop_value = plan[n].pv;
			end else begin
				// push share drifts so the store swings between full and empty
				case (((n - PLAN_LEN) / 40) % 4)
					0: push_pct = 85;
					1: push_pct = 20;
					2: push_pct = 55;
					default: push_pct = 70;
				endcase
				it.mode         = ($urandom_range(99) < push_pct) ?
					mss_pkg::MODE_PUSH : mss_pkg::MODE_POP;
				it.stack_number = mss_pkg::STACK_W'($urandom_range(mss_pkg::NUM_STACKS - 1));
				it.push_value   = $urandom();
				typed           = 1'b0;
				fixed           = '0;
			end
			offer_beat(it, typed, fixed);
			if (burst_left > 0) begin
				burst_left--;
			end else begin
				burst_left = ($urandom_range(3) == 0) ? $urandom_range(20, 40)
					: $urandom_range(0, 10);
				// keep offering while the receiver is held off
				gap = rx_holding ? 0 : $urandom_range(0, 6);
				if (gap > 0) begin
					in_valid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
		in_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		// leave margin for stray results
		repeat (8) @(posedge clk);
		if (pending_results.size() != 0)
			log_mismatch("results still expected at end");
		if (errors == 0)
			$display("tb_top: PASS");
		else
			$display("tb_top: FAIL");
		$finish;
	end

	// Receiver: ready follows one of four patterns, redrawn at random; two long
	// hold-offs let the output register fill and back up the input side.
	initial begin : rx_drive
		int cyc;
		int style;
		int hold_left;
		int next_hold_at;
		cyc          = 0;
		style        = 0;
		hold_left    = 0;
		next_hold_at = 150;
		out_ready    = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			cyc++;
			if (cyc % 50 == 0)
				style = $urandom_range(3);
			if (hold_left == 0 && beats_in >= next_hold_at && next_hold_at <= 350) begin
				hold_left    = HOLD_LEN;
				next_hold_at = next_hold_at + 200;
			end
			if (hold_left > 0) begin
				hold_left--;
				rx_holding = 1'b1;
				out_ready <= 1'b0;
			end else begin
				rx_holding = 1'b0;
				case (style)
					0: out_ready <= 1'b1;
					1: out_ready <= (cyc % 3 != 0);
					2: out_ready <= 1'($urandom_range(1));
					default: out_ready <= ($urandom_range(9) != 0);
				endcase
			end
		end
	end

	// Result check on the falling edge: a beat seen here is taken at the next
	// rising edge.
	always @(negedge clk) begin : rx_check
		mss_pkg::out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				log_mismatch($sformatf("unexpected result ok=%0b val=%0h",
					out_data.ok, out_data.pop_value));
			end else begin
				want = pending_results.pop_front();
				if (out_data.ok !== want.ok)
					log_mismatch($sformatf("ok %0b, want %0b", out_data.ok, want.ok));
				if (out_data.pop_value !== want.pop_value)
					log_mismatch($sformatf("pop_value %08h, want %08h",
						out_data.pop_value, want.pop_value));
			end
		end
	end

endmodule
